// ===== sv/b64e_pkg.sv =====
// package: group type, queue sizing and base64 alphabet lookup
`default_nettype none

package b64e_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] UPPER_BASE = 8'h41;
  localparam logic [7:0] LOWER_BASE = 8'h61;
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  typedef struct packed {
    logic [5:0] sx0;
    logic [5:0] sx1;
    logic [5:0] sx2;
    logic [5:0] sx3;
    logic [1:0] npad;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    priority if (v < 6'd26) begin
      c = 8'(UPPER_BASE + w);
    end else if (v < 6'd52) begin
      c = 8'(LOWER_BASE + w - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'(DIGIT_BASE + w - 8'd52);
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/b64e_front.sv =====
// front end: collects bytes into groups and pushes finished groups into the queue
`default_nettype none

module b64e_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              flush,
  input  wire b64e_pkg::q_status_t q_status,
  output logic                   push,
  output b64e_pkg::group_t       push_group
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push       = 1'b0;
    count_next = count;
    push_group.sx0  = b0[7:2];
    push_group.sx1  = {b0[1:0], b1[7:4]};
    push_group.sx2  = {b1[3:0], data_byte[7:6]};
    push_group.sx3  = data_byte[5:0];
    push_group.npad = 2'd0;
    if (accept) begin
      if (flush) begin
        count_next = 2'd0;
        push       = (count != 2'd0);
        if (count == 2'd1) begin
          push_group.sx1  = {b0[1:0], 4'b0000};
          push_group.npad = 2'd2;
        end else begin
          push_group.sx2  = {b1[3:0], 2'b00};
          push_group.npad = 2'd1;
        end
      end else if (count == 2'd2) begin
        count_next = 2'd0;
        push       = 1'b1;
      end else begin
        count_next = 2'(count + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !flush && count == 2'd0) begin
      b0 <= data_byte;
    end
    if (accept && !flush && count == 2'd1) begin
      b1 <= data_byte;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("pending count out of range");

  assert property (@(posedge clk) disable iff (rst) push |-> accept)
    else $error("group pushed without a request");

  assert property (@(posedge clk) disable iff (rst)
    (accept && flush) |=> (count == 2'd0))
    else $error("flush did not clear pending count");

endmodule

`default_nettype wire

// ===== sv/b64e_queue.sv =====
// two-entry queue of groups between front and back ends
`default_nettype none

module b64e_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire b64e_pkg::group_t    push_group,
  input  wire logic                pop,
  output b64e_pkg::group_t         head,
  output b64e_pkg::q_status_t      status
);

  b64e_pkg::group_t mem [b64e_pkg::QDEPTH];
  logic [b64e_pkg::QPTR_W-1:0] wr_ptr;
  logic [b64e_pkg::QPTR_W-1:0] rd_ptr;
  logic [b64e_pkg::QCNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + b64e_pkg::QCNT_W'(1);
        2'b01:   count <= count - b64e_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !status.full)
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> !status.empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    count <= b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

// ===== sv/b64e_back.sv =====
// back end: turns queued groups into four registered characters each
`default_nettype none

module b64e_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire b64e_pkg::group_t    head,
  input  wire b64e_pkg::q_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_char,
  output logic                     last
);

  logic [1:0] idx;
  logic       load;
  logic [5:0] sx;
  logic [7:0] char_next;
  logic       is_pad;

  assign load = !q_status.empty && (!out_valid || out_ready);
  assign pop  = load && (idx == 2'd3);

  always_comb begin
    unique case (idx)
      2'd0: sx = head.sx0;
      2'd1: sx = head.sx1;
      2'd2: sx = head.sx2;
      2'd3: sx = head.sx3;
    endcase
    is_pad    = ({1'b0, idx} >= 3'(3'd4 - {1'b0, head.npad}));
    char_next = is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= idx + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      last     <= (idx == 2'd3);
    end
  end

  assert property (@(posedge clk) disable iff (rst) load |=> out_valid)
    else $error("loaded character not presented");

  assert property (@(posedge clk) disable iff (rst) pop |=> (idx == 2'd0))
    else $error("character index not realigned after group");

  assert property (@(posedge clk) disable iff (rst)
    (load && idx == 2'd0) |-> (head.npad != 2'd3))
    else $error("invalid pad count in group");

endmodule

`default_nettype wire

// ===== sv/base64_stream_encoder.sv =====
// top level: streaming base64 encoder, front end, group queue and character back end
// Streaming RFC 4648 Base64 encoder. Each input request carries one byte, or a flush
// mark that ends the data and emits the padded final group if bytes are pending. Input
// requests are accepted while the two-group queue has room; the character back end
// sends one character per cycle while a group is queued and the receiver is ready, so
// each group of three bytes becomes four characters and the sustained rate is set by
// the single-character output register. The last flag marks the fourth character.
`default_nettype none

module base64_stream_encoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       flush,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            last
);

  b64e_pkg::q_status_t q_status;
  b64e_pkg::group_t    push_group;
  b64e_pkg::group_t    head;
  logic                push;
  logic                pop;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .flush      (flush),
    .q_status   (q_status),
    .push       (push),
    .push_group (push_group)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== tb/base64_stream_encoder_tb.sv =====
// testbench: base64 stream encoder, scored against its own group encoder under random handshakes
`default_nettype none

module base64_stream_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_REQS = 100;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       flush;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       last;

  bit          src_steady;
  bit          sink_steady;
  bit          hold_req;
  int unsigned idle_cycles;

  class b64_scoreboard;
    logic [7:0]  held [2];
    int unsigned held_cnt;
    logic [8:0]  expected_chars [$];
    int unsigned mismatches;

    function new();
      held_cnt = 0;
      mismatches = 0;
    endfunction

    function void push_sextet(logic [5:0] sx, logic is_last);
      logic [7:0] ch;
      ch = B64_ALPHABET[sx];
      expected_chars.push_back({is_last, ch});
    endfunction

    function void note_request(logic [7:0] b, logic f);
      logic [7:0] b0;
      logic [7:0] b1;
      b0 = held[0];
      b1 = held[1];
      if (f) begin
        if (held_cnt == 0) return;
        push_sextet(b0[7:2], 1'b0);
        if (held_cnt == 1) begin
          push_sextet({b0[1:0], 4'b0000}, 1'b0);
          expected_chars.push_back({1'b0, b64e_pkg::PAD_CHAR});
        end else begin
          push_sextet({b0[1:0], b1[7:4]}, 1'b0);
          push_sextet({b1[3:0], 2'b00}, 1'b0);
        end
        expected_chars.push_back({1'b1, b64e_pkg::PAD_CHAR});
        held_cnt = 0;
      end else if (held_cnt < 2) begin
        held[held_cnt] = b;
        held_cnt++;
      end else begin
        push_sextet(b0[7:2], 1'b0);
        push_sextet({b0[1:0], b1[7:4]}, 1'b0);
        push_sextet({b1[3:0], b[7:6]}, 1'b0);
        push_sextet(b[5:0], 1'b1);
        held_cnt = 0;
      end
    endfunction

    function void check_char(logic [7:0] c, logic l);
      logic [8:0] want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char %h last %b at %0t", c, l, $realtime);
        return;
      end
      want = expected_chars.pop_front();
      if (want[7:0] !== c || want[8] !== l) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: char exp %h got %h, last exp %b got %b",
                   $realtime, want[7:0], c, want[8], l);
      end
    endfunction

    function int unsigned outstanding();
      return expected_chars.size();
    endfunction
  endclass

  b64_scoreboard sb = new();

  base64_stream_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .flush     (flush),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // entered and left at a falling edge
  task automatic send_req(input logic [7:0] b, input logic f);
    int unsigned gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_byte <= b;
    flush <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_request(data_byte, flush);
      if (out_valid && out_ready) sb.check_char(out_char, last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : sink
    int unsigned stall;
    int unsigned run;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = pick_gap(sink_steady);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(negedge clk);
    end
  end

  initial begin : source
    logic [7:0] b;
    logic       f;
    in_valid = 1'b0;
    data_byte = 8'h00;
    flush = 1'b0;
    out_ready = 1'b0;
    rst = 1'b1;
    src_steady = 1'b0;
    sink_steady = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // flush with nothing pending, full groups at both extremes
    send_req(8'h00, 1'b1);
    send_req(8'h00, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(8'hff, 1'b0);
    send_req(8'hff, 1'b0);
    send_req(8'hff, 1'b0);
    // one and two bytes pending, flush carrying a stray byte
    send_req(8'h3f, 1'b0);
    send_req(8'ha5, 1'b1);
    send_req(8'hfb, 1'b0);
    send_req(8'hef, 1'b0);
    send_req(8'hff, 1'b1);
    send_req(8'h80, 1'b1);
    send_req(8'h80, 1'b0);
    send_req(8'h01, 1'b0);
    send_req(8'hfe, 1'b0);
    send_req(8'h7f, 1'b0);
    send_req(8'h00, 1'b1);

    // long receiver hold while the sender keeps sending until back-pressured, then random bytes and flushes
    src_steady = 1'b1;
    sink_steady = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i >= 30 && i % 20 == 10) begin
        src_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      b = 8'($urandom_range(0, 255));
      f = ($urandom_range(0, 5) == 0);
      send_req(b, f);
    end
    send_req(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
